@@ rtl/core/ols_pkg.sv @@
// shared types and codes for the ordered list store
package ols_pkg;

  localparam int unsigned DEF_CAPACITY = 16;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned KIND_W       = 3;
  localparam int unsigned STATUS_W     = 2;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_NEW    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_APPEND = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FRONT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_BACK   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd4;
  localparam logic [KIND_W-1:0] KIND_DUMP   = 3'd5;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd3;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD_HEAD,
    CELL_APPEND,
    CELL_ROTATE,
    CELL_DROP
  } cell_op_e;

  typedef struct packed {
    cell_op_e                   op;
    logic signed [DATA_W-1:0]   value;
  } cell_ctl_t;

endpackage

@@ rtl/core/ordered_list_store_unit.sv @@
// ordered list store: request decode, sequencing of the cell chain, result register
// new, append, remove front/back and the empty and full errors register their result in the cycle after accept
// remove value steps the n active entries past the head, dropping the first match; result after the last step
// dump emits one entry per cycle while the result register is free, as the chain rotates, n results in all
// one request at a time: a request is taken only while the sequencer is idle and the result register is free;
// reset clears count, sequencer, valid
module ordered_list_store_unit #(
  parameter int unsigned CAPACITY = ols_pkg::DEF_CAPACITY
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [ols_pkg::KIND_W-1:0]           in_kind_i,
  input  logic signed [ols_pkg::DATA_W-1:0]    in_value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [ols_pkg::STATUS_W-1:0]         out_status_o,
  output logic signed [ols_pkg::DATA_W-1:0]    out_entry_o,
  output logic                                 out_last_o
);
  import ols_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DUMP   = 2'd1;
  localparam logic [1:0] ST_REMOVE = 2'd2;

  logic [1:0]               state_q, state_d;
  logic [CNT_W-1:0]         count_q, count_d;
  logic [CNT_W-1:0]         rem_q, rem_d;
  logic                     found_q, found_d;
  logic signed [DATA_W-1:0] value_q, value_d;

  logic                     out_valid_q;
  logic [STATUS_W-1:0]      status_q;
  logic signed [DATA_W-1:0] entry_q;
  logic                     last_q;

  logic                     emit;
  logic [STATUS_W-1:0]      emit_status;
  logic signed [DATA_W-1:0] emit_entry;
  logic                     emit_last;

  logic                     out_free, accept, hit, empty;
  cell_ctl_t                ctl;
  logic signed [DATA_W-1:0] head;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign empty      = (count_q == '0);
  assign hit        = !found_q && (head == value_q);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rem_d       = rem_q;
    found_d     = found_q;
    value_d     = value_q;
    ctl.op      = CELL_HOLD;
    ctl.value   = in_value_i;
    emit        = 1'b0;
    emit_status = STATUS_OK;
    emit_entry  = '0;
    emit_last   = 1'b1;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          emit = 1'b1;
          case (in_kind_i)
            KIND_NEW: begin
              ctl.op  = CELL_LOAD_HEAD;
              count_d = CNT_ONE;
            end
            KIND_APPEND: begin
              if (count_q == CNT_FULL) begin
                emit_status = STATUS_FULL;
              end else begin
                ctl.op  = CELL_APPEND;
                count_d = count_q + CNT_ONE;
              end
            end
            KIND_FRONT: begin
              if (empty) begin
                emit_status = STATUS_EMPTY;
              end else begin
                ctl.op  = CELL_DROP;
                count_d = count_q - CNT_ONE;
              end
            end
            KIND_BACK: begin
              if (empty) emit_status = STATUS_EMPTY;
              else count_d = count_q - CNT_ONE;
            end
            KIND_REMOVE: begin
              if (empty) begin
                emit_status = STATUS_EMPTY;
              end else begin
                emit    = 1'b0;
                state_d = ST_REMOVE;
                rem_d   = count_q;
                found_d = 1'b0;
                value_d = in_value_i;
              end
            end
            KIND_DUMP: begin
              if (empty) begin
                emit_status = STATUS_EMPTY;
              end else begin
                emit    = 1'b0;
                state_d = ST_DUMP;
                rem_d   = count_q;
              end
            end
            default: emit_status = STATUS_OK;
          endcase
        end
      end
      ST_DUMP: begin
        if (out_free) begin
          ctl.op     = CELL_ROTATE;
          emit       = 1'b1;
          emit_entry = head;
          emit_last  = (rem_q == CNT_ONE);
          rem_d      = rem_q - CNT_ONE;
          if (rem_q == CNT_ONE) state_d = ST_IDLE;
        end
      end
      ST_REMOVE: begin
        if (out_free) begin
          // first match leaves the ring, the rest keeps rotating back into order
          if (hit) begin
            ctl.op  = CELL_DROP;
            count_d = count_q - CNT_ONE;
            found_d = 1'b1;
          end else begin
            ctl.op  = CELL_ROTATE;
          end
          rem_d = rem_q - CNT_ONE;
          if (rem_q == CNT_ONE) begin
            emit        = 1'b1;
            emit_status = (found_q || hit) ? STATUS_OK : STATUS_NOTFOUND;
            state_d     = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  ols_chain #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_chain (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .count_i (count_q),
    .head_o  (head)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rem_q       <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      rem_q   <= rem_d;
      found_q <= found_d;
      if (emit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    if (emit) begin
      status_q <= emit_status;
      entry_q  <= emit_entry;
      last_q   <= emit_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = status_q;
  assign out_entry_o  = entry_q;
  assign out_last_o   = last_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_FULL)
    else $error("entry count above capacity");

  a_busy_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> rem_q != '0)
    else $error("sequencer busy with no steps left");

  a_found_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REMOVE && found_q) |-> count_q < CNT_FULL)
    else $error("match removed but count still at capacity");

  a_dump_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DUMP && out_free && rem_q == CNT_ONE)
      |=> (state_q == ST_IDLE && out_valid_o && out_last_o))
    else $error("dump did not close with a last entry");

endmodule

@@ rtl/core/ols_cell.sv @@
// one storage cell of the list chain
module ols_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 5
) (
  input  logic                               clk_i,
  input  ols_pkg::cell_ctl_t                 ctl_i,
  input  logic [CNT_W-1:0]                   count_i,
  input  logic signed [ols_pkg::DATA_W-1:0]  next_i,
  input  logic signed [ols_pkg::DATA_W-1:0]  head_i,
  output logic signed [ols_pkg::DATA_W-1:0]  data_o
);
  import ols_pkg::*;

  localparam logic [CNT_W-1:0] IDX_C   = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] IDX_N   = CNT_W'(IDX + 1);
  localparam bit               IS_HEAD = (IDX == 0);

  logic signed [DATA_W-1:0] data_q, data_d;
  logic                     take_next, is_tail;

  assign take_next = (IDX_N < count_i);
  assign is_tail   = (IDX_N == count_i);

  always_comb begin
    data_d = data_q;
    case (ctl_i.op)
      CELL_LOAD_HEAD: begin
        if (IS_HEAD) data_d = ctl_i.value;
      end
      CELL_APPEND: begin
        if (IDX_C == count_i) data_d = ctl_i.value;
      end
      CELL_ROTATE: begin
        // the tail takes the head so the active entries form a ring
        if (take_next) data_d = next_i;
        else if (is_tail) data_d = head_i;
      end
      CELL_DROP: begin
        if (take_next) data_d = next_i;
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

@@ rtl/core/ols_chain.sv @@
// row of list cells, each handing its entry to the cell before it
module ols_chain #(
  parameter int unsigned CAPACITY = ols_pkg::DEF_CAPACITY,
  parameter int unsigned CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                               clk_i,
  input  ols_pkg::cell_ctl_t                 ctl_i,
  input  logic [CNT_W-1:0]                   count_i,
  output logic signed [ols_pkg::DATA_W-1:0]  head_o
);
  import ols_pkg::*;

  logic signed [DATA_W-1:0] cell_data [CAPACITY];
  logic signed [DATA_W-1:0] cell_next [CAPACITY];

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == CAPACITY - 1) begin : g_end
      assign cell_next[g] = '0;
    end else begin : g_mid
      assign cell_next[g] = cell_data[g+1];
    end

    ols_cell #(
      .IDX   (g),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl_i),
      .count_i (count_i),
      .next_i  (cell_next[g]),
      .head_i  (cell_data[0]),
      .data_o  (cell_data[g])
    );
  end

  assign head_o = cell_data[0];

endmodule
